### src/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int DATA_W       = 20;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    COMP_X = 2'd0,
    COMP_Y = 2'd1,
    COMP_Z = 2'd2,
    COMP_W = 2'd3
  } comp_e_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] mxx;
    logic signed [DATA_W-1:0] mxy;
    logic signed [DATA_W-1:0] mxz;
    logic signed [DATA_W-1:0] myx;
    logic signed [DATA_W-1:0] myy;
    logic signed [DATA_W-1:0] myz;
    logic signed [DATA_W-1:0] mzx;
    logic signed [DATA_W-1:0] mzy;
    logic signed [DATA_W-1:0] mzz;
    logic signed [DATA_W-1:0] mww;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] quat_x;
    logic signed [DATA_W-1:0] quat_y;
    logic signed [DATA_W-1:0] quat_z;
    logic signed [DATA_W-1:0] quat_w;
    logic                     invalid;
  } out_t;

endpackage

### src/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Fixed-point rotation matrix to quaternion conversion, fully pipelined:
// restoring square roots, then bit-per-stage dividers by 2*s and sqrt(ww).
// ----------------------------------------------------------------------------
//  channel | signals                      | transaction
//  input   | in_valid, in_ready, in_data  | one matrix (in_t)
//  output  | out_valid, out_ready, out_data | one quaternion (out_t)
//
//  one transaction per cycle sustained while the output is not stalled
//  pipeline: S = root stages ((21+FRAC_BITS+1)/2),
//    N1 = 21+FRAC_BITS and N2 = 31+FRAC_BITS divider stages
//  the whole pipeline advances when the output register is empty or taken
//  reset clears the valid bits only
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int F    = FRAC_BITS;
  localparam int DW   = DATA_W;
  localparam int RADW = DW + 2;
  localparam int MW   = DW + 1;
  localparam int SQN  = ((DW + 1 + F + 1) / 2) * 2;
  localparam int SQS  = SQN / 2;
  localparam int SRW  = SQS + 3;
  localparam int N1   = MW + F;
  localparam int D1W  = SQS + 1;
  localparam int R1W  = D1W + 1;
  localparam int QW   = 31;
  localparam int N2   = QW + F;
  localparam int R2W  = SQS + 1;
  localparam int CW   = (N1 > QW) ? N1 : QW;
  localparam int NL   = 4;

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // front end
  logic signed [RADW-1:0] xx, xy, xz, yx, yy, yz, zx, zy, zz, ww;
  logic signed [RADW-1:0] tr, rad, sa, sb, sc, dzy, dxz, dyx;
  logic signed [RADW-1:0] num [0:NL-1];
  comp_e_t                sel0;
  logic                   inv0;

  function automatic logic signed [RADW-1:0] sx(input logic signed [DW-1:0] v);
    return {{(RADW-DW){v[DW-1]}}, v};
  endfunction

  always_comb begin
    xx = sx(in_data.mxx); xy = sx(in_data.mxy); xz = sx(in_data.mxz);
    yx = sx(in_data.myx); yy = sx(in_data.myy); yz = sx(in_data.myz);
    zx = sx(in_data.mzx); zy = sx(in_data.mzy); zz = sx(in_data.mzz);
    ww = sx(in_data.mww);
    tr  = xx + yy + zz;
    sa  = xy + yx;
    sb  = zx + xz;
    sc  = yz + zy;
    dzy = zy - yz;
    dxz = xz - zx;
    dyx = yx - xy;
    num[0] = '0; num[1] = '0; num[2] = '0; num[3] = '0;
    if (!tr[RADW-1]) begin
      sel0 = COMP_W;
      rad  = tr + ww;
      num[0] = dzy; num[1] = dxz; num[2] = dyx;
    end else if ((zz > ((yy > xx) ? yy : xx))) begin
      sel0 = COMP_Z;
      rad  = zz - (xx + yy) + ww;
      num[0] = sb; num[1] = sc; num[3] = dyx;
    end else if (yy > xx) begin
      sel0 = COMP_Y;
      rad  = yy - (zz + xx) + ww;
      num[2] = sc; num[0] = sa; num[3] = dxz;
    end else begin
      sel0 = COMP_X;
      rad  = xx - (yy + zz) + ww;
      num[1] = sa; num[2] = sb; num[3] = dzy;
    end
    inv0 = rad[RADW-1] || ww[RADW-1] || (ww == '0);
  end

  // square root stages
  logic                 sq_vld  [0:SQS];
  logic [SQN-1:0]       sq_rad  [0:SQS];
  logic [SRW-1:0]       sq_rem  [0:SQS];
  logic [SQS-1:0]       sq_root [0:SQS];
  logic [SQN-1:0]       sw_rad  [0:SQS];
  logic [SRW-1:0]       sw_rem  [0:SQS];
  logic [SQS-1:0]       sw_root [0:SQS];
  logic [MW-1:0]        sq_mag  [0:SQS][0:NL-1];
  logic                 sq_neg  [0:SQS][0:NL-1];
  comp_e_t              sq_sel  [0:SQS];
  logic                 sq_inv  [0:SQS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (adv) begin
      sq_vld[0] <= in_valid;
    end
    if (adv) begin
      sq_rad[0]  <= SQN'({rad[MW-1:0], {F{1'b0}}});
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sw_rad[0]  <= SQN'({in_data.mww, {F{1'b0}}});
      sw_rem[0]  <= '0;
      sw_root[0] <= '0;
      sq_sel[0]  <= sel0;
      sq_inv[0]  <= inv0;
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_in
    logic signed [RADW-1:0] a;
    assign a = num[l][RADW-1] ? -num[l] : num[l];
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_mag[0][l] <= a[MW-1:0];
        sq_neg[0][l] <= num[l][RADW-1];
      end
    end
  end

  for (genvar k = 0; k < SQS; k++) begin : g_sq
    logic [SRW-1:0] rs, rt, ws, wt;
    logic           rge, wge;
    always_comb begin
      rs  = {sq_rem[k][SRW-3:0], sq_rad[k][SQN-1 -: 2]};
      rt  = {1'b0, sq_root[k], 2'b01};
      rge = rs >= rt;
      ws  = {sw_rem[k][SRW-3:0], sw_rad[k][SQN-1 -: 2]};
      wt  = {1'b0, sw_root[k], 2'b01};
      wge = ws >= wt;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else if (adv) begin
        sq_vld[k+1] <= sq_vld[k];
      end
      if (adv) begin
        sq_rad[k+1]  <= sq_rad[k] << 2;
        sq_rem[k+1]  <= rge ? rs - rt : rs;
        sq_root[k+1] <= {sq_root[k][SQS-2:0], rge};
        sw_rad[k+1]  <= sw_rad[k] << 2;
        sw_rem[k+1]  <= wge ? ws - wt : ws;
        sw_root[k+1] <= {sw_root[k][SQS-2:0], wge};
        sq_mag[k+1]  <= sq_mag[k];
        sq_neg[k+1]  <= sq_neg[k];
        sq_sel[k+1]  <= sq_sel[k];
        sq_inv[k+1]  <= sq_inv[k];
      end
    end
  end

  // divide by 2*s
  logic                 d1_vld  [0:N1];
  logic [N1-1:0]        d1_nq   [0:N1][0:NL-1];
  logic [R1W-1:0]       d1_rem  [0:N1][0:NL-1];
  logic                 d1_neg  [0:N1][0:NL-1];
  logic [D1W-1:0]       d1_div  [0:N1];
  logic [QW-1:0]        d1_half [0:N1];
  logic [SQS-1:0]       d1_r    [0:N1];
  comp_e_t              d1_sel  [0:N1];
  logic                 d1_inv  [0:N1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_vld[0] <= 1'b0;
    end else if (adv) begin
      d1_vld[0] <= sq_vld[SQS];
    end
    if (adv) begin
      d1_div[0]  <= {sq_root[SQS], 1'b0};
      d1_half[0] <= {{(QW-SQS+1){1'b0}}, sq_root[SQS][SQS-1:1]};
      d1_r[0]    <= sw_root[SQS];
      d1_sel[0]  <= sq_sel[SQS];
      d1_inv[0]  <= sq_inv[SQS] || (sq_root[SQS] == '0);
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_d1l
    always_ff @(posedge clk) begin
      if (adv) begin
        d1_nq[0][l]  <= {sq_mag[SQS][l], {F{1'b0}}};
        d1_rem[0][l] <= '0;
        d1_neg[0][l] <= sq_neg[SQS][l];
      end
    end
    for (genvar k = 0; k < N1; k++) begin : g_st
      logic [R1W-1:0] rs, dv;
      logic           ge;
      always_comb begin
        rs = {d1_rem[k][l][R1W-2:0], d1_nq[k][l][N1-1]};
        dv = {1'b0, d1_div[k]};
        ge = rs >= dv;
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          d1_nq[k+1][l]  <= {d1_nq[k][l][N1-2:0], ge};
          d1_rem[k+1][l] <= ge ? rs - dv : rs;
          d1_neg[k+1][l] <= d1_neg[k][l];
        end
      end
    end
  end

  for (genvar k = 0; k < N1; k++) begin : g_d1
    always_ff @(posedge clk) begin
      if (rst) begin
        d1_vld[k+1] <= 1'b0;
      end else if (adv) begin
        d1_vld[k+1] <= d1_vld[k];
      end
      if (adv) begin
        d1_div[k+1]  <= d1_div[k];
        d1_half[k+1] <= d1_half[k];
        d1_r[k+1]    <= d1_r[k];
        d1_sel[k+1]  <= d1_sel[k];
        d1_inv[k+1]  <= d1_inv[k];
      end
    end
  end

  // divide by sqrt(ww)
  logic                 d2_vld [0:N2];
  logic [N2-1:0]        d2_nq  [0:N2][0:NL-1];
  logic [R2W-1:0]       d2_rem [0:N2][0:NL-1];
  logic                 d2_neg [0:N2][0:NL-1];
  logic [SQS-1:0]       d2_div [0:N2];
  logic                 d2_inv [0:N2];

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_vld[0] <= 1'b0;
    end else if (adv) begin
      d2_vld[0] <= d1_vld[N1];
    end
    if (adv) begin
      d2_div[0] <= d1_r[N1];
      d2_inv[0] <= d1_inv[N1];
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_d2l
    logic [CW-1:0] qe;
    logic [QW-1:0] mc;
    logic          is_root;
    always_comb begin
      qe      = CW'(d1_nq[N1][l]);
      is_root = (d1_sel[N1] == comp_e_t'(l));
      if (is_root) begin
        mc = d1_half[N1];
      end else if (qe > CW'({QW{1'b1}})) begin
        mc = '1;
      end else begin
        mc = qe[QW-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        d2_nq[0][l]  <= {mc, {F{1'b0}}};
        d2_rem[0][l] <= '0;
        d2_neg[0][l] <= d1_neg[N1][l] && !is_root;
      end
    end
    for (genvar k = 0; k < N2; k++) begin : g_st
      logic [R2W-1:0] rs, dv;
      logic           ge;
      always_comb begin
        rs = {d2_rem[k][l][R2W-2:0], d2_nq[k][l][N2-1]};
        dv = {1'b0, d2_div[k]};
        ge = rs >= dv;
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          d2_nq[k+1][l]  <= {d2_nq[k][l][N2-2:0], ge};
          d2_rem[k+1][l] <= ge ? rs - dv : rs;
          d2_neg[k+1][l] <= d2_neg[k][l];
        end
      end
    end
  end

  for (genvar k = 0; k < N2; k++) begin : g_d2
    always_ff @(posedge clk) begin
      if (rst) begin
        d2_vld[k+1] <= 1'b0;
      end else if (adv) begin
        d2_vld[k+1] <= d2_vld[k];
      end
      if (adv) begin
        d2_div[k+1] <= d2_div[k];
        d2_inv[k+1] <= d2_inv[k];
      end
    end
  end

  // saturate and register
  logic [DW-1:0] res [0:NL-1];

  for (genvar l = 0; l < NL; l++) begin : g_sat
    logic [N2-1:0] q;
    always_comb begin
      q = d2_nq[N2][l];
      if (d2_inv[N2]) begin
        res[l] = '0;
      end else if (d2_neg[N2][l]) begin
        res[l] = (q > N2'(2 ** (DW - 1))) ? {1'b1, {(DW-1){1'b0}}} : -q[DW-1:0];
      end else begin
        res[l] = (q > N2'(2 ** (DW - 1) - 1)) ? {1'b0, {(DW-1){1'b1}}} : q[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d2_vld[N2];
    end
    if (adv) begin
      out_data.quat_x  <= res[0];
      out_data.quat_y  <= res[1];
      out_data.quat_z  <= res[2];
      out_data.quat_w  <= res[3];
      out_data.invalid <= d2_inv[N2];
    end
  end

endmodule

### src/rmq_checker.sv
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
module rmq_checker
  import rmq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // flagged results carry zeros
  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.invalid |->
      out_data.quat_x == '0 && out_data.quat_y == '0 &&
      out_data.quat_z == '0 && out_data.quat_w == '0)
    else $error("invalid result with nonzero components");

  // empty output never blocks input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // nothing out right after reset
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);

### verif/rotation_matrix_to_quaternion_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_chk
// Watches both channels, predicts each quaternion from the accepted matrix in
// fixed point and compares every output transaction field by field.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_chk
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   fail_count,
  output int   pending,
  output int   checked
);

  out_t quat_fifo[$];

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint scaled_div(longint d, longint unsigned den);
    longint unsigned mag, q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q = (mag << FRAC_BITS) / den;
    if (q > 64'd2147483647) q = 64'd2147483647;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [DATA_W-1:0] clamp20(longint v);
    if (v > 524287) v = 524287;
    if (v < -524288) v = -524288;
    return v[DATA_W-1:0];
  endfunction

  function automatic out_t predict_quat(in_t m);
    longint xx, xy, xz, yx, yy, yz, zx, zy, zz, ww, tr, rad, one;
    longint q[4];
    longint unsigned s, twice, r;
    comp_e_t h;
    out_t o;
    xx = longint'(m.mxx); xy = longint'(m.mxy); xz = longint'(m.mxz);
    yx = longint'(m.myx); yy = longint'(m.myy); yz = longint'(m.myz);
    zx = longint'(m.mzx); zy = longint'(m.mzy); zz = longint'(m.mzz);
    ww = longint'(m.mww);
    one = 64'sd1 <<< FRAC_BITS;
    o = '0;
    o.invalid = 1'b1;
    h = COMP_X;
    tr = xx + yy + zz;
    if (tr >= 0) begin
      rad = tr + ww;
    end else begin
      if (yy > xx) h = COMP_Y;
      if (zz > ((h == COMP_Y) ? yy : xx)) h = COMP_Z;
      case (h)
        COMP_X: rad = xx - (yy + zz) + ww;
        COMP_Y: rad = yy - (zz + xx) + ww;
        default: rad = zz - (xx + yy) + ww;
      endcase
    end
    if (rad < 0 || ww <= 0) return o;
    s = int_sqrt(longint'(rad) << FRAC_BITS);
    if (s == 0) return o;
    twice = s << 1;
    if (tr >= 0) begin
      q[COMP_W] = s >> 1;
      q[COMP_X] = scaled_div(zy - yz, twice);
      q[COMP_Y] = scaled_div(xz - zx, twice);
      q[COMP_Z] = scaled_div(yx - xy, twice);
    end else if (h == COMP_X) begin
      q[COMP_X] = s >> 1;
      q[COMP_Y] = scaled_div(xy + yx, twice);
      q[COMP_Z] = scaled_div(zx + xz, twice);
      q[COMP_W] = scaled_div(zy - yz, twice);
    end else if (h == COMP_Y) begin
      q[COMP_Y] = s >> 1;
      q[COMP_Z] = scaled_div(yz + zy, twice);
      q[COMP_X] = scaled_div(xy + yx, twice);
      q[COMP_W] = scaled_div(xz - zx, twice);
    end else begin
      q[COMP_Z] = s >> 1;
      q[COMP_X] = scaled_div(zx + xz, twice);
      q[COMP_Y] = scaled_div(yz + zy, twice);
      q[COMP_W] = scaled_div(yx - xy, twice);
    end
    if (ww != one) begin
      r = int_sqrt(longint'(ww) << FRAC_BITS);
      if (r == 0) return o;
      for (int i = 0; i < 4; i++) q[i] = scaled_div(q[i], r);
    end
    o.quat_x = clamp20(q[COMP_X]);
    o.quat_y = clamp20(q[COMP_Y]);
    o.quat_z = clamp20(q[COMP_Z]);
    o.quat_w = clamp20(q[COMP_W]);
    o.invalid = 1'b0;
    return o;
  endfunction

  always @(posedge clk) begin
    out_t exp_q;
    if (rst) begin
      fail_count <= 0;
      checked <= 0;
      pending <= 0;
    end else begin
      if (in_valid && in_ready) quat_fifo.push_back(predict_quat(in_data));
      if (out_valid && out_ready) begin
        checked <= checked + 1;
        if (quat_fifo.size() == 0) begin
          $error("output transaction with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_q = quat_fifo.pop_front();
          if (exp_q != out_data) begin
            fail_count <= fail_count + 1;
            if (exp_q.quat_x != out_data.quat_x)
              $error("quat_x exp %0d got %0d", exp_q.quat_x, out_data.quat_x);
            if (exp_q.quat_y != out_data.quat_y)
              $error("quat_y exp %0d got %0d", exp_q.quat_y, out_data.quat_y);
            if (exp_q.quat_z != out_data.quat_z)
              $error("quat_z exp %0d got %0d", exp_q.quat_z, out_data.quat_z);
            if (exp_q.quat_w != out_data.quat_w)
              $error("quat_w exp %0d got %0d", exp_q.quat_w, out_data.quat_w);
            if (exp_q.invalid != out_data.invalid)
              $error("invalid exp %0d got %0d", exp_q.invalid, out_data.invalid);
          end
        end
      end
      pending <= quat_fifo.size();
    end
  end

endmodule

### verif/rotation_matrix_to_quaternion_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// Drives directed corner matrices and random, scaled and noisy
// matrices through the converter with bursty input and stalled output.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int N_RAND = 2000;
  localparam int LAT = 120;
  localparam int LIMIT = 400000;

  logic clk, rst, in_valid, in_ready, out_valid, out_ready;
  in_t  in_data;
  out_t out_data;
  int   fail_count, pending, checked, cycles, sent;

  rotation_matrix_to_quaternion u_top (.*);
  rotation_matrix_to_quaternion_chk u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout");
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stall pattern
  int stall_mode;
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(3, 0) != 0);
      default: out_ready <= ($urandom_range(3, 0) == 0);
    endcase
  end
  always @(posedge clk) if ($urandom_range(300, 0) == 0) stall_mode <= $urandom_range(2, 0);

  function automatic logic [19:0] pick_val();
    case ($urandom_range(5, 0))
      0: return 20'h7FFFF;
      1: return 20'h80000;
      2: return 20'd0;
      3: return 20'h10000;
      default: return DATA_W'($urandom());
    endcase
  endfunction

  function automatic in_t rand_mat();
    in_t m;
    int kind;
    logic [223:0] raw;
    kind = $urandom_range(9, 0);
    m.mxx = DATA_W'($urandom_range(65536, 0) - 32768);
    m.mxy = DATA_W'($urandom_range(131072, 0) - 65536);
    m.mxz = DATA_W'($urandom_range(131072, 0) - 65536);
    m.myx = DATA_W'($urandom_range(131072, 0) - 65536);
    m.myy = DATA_W'($urandom_range(131072, 0) - 65536);
    m.myz = DATA_W'($urandom_range(131072, 0) - 65536);
    m.mzx = DATA_W'($urandom_range(131072, 0) - 65536);
    m.mzy = DATA_W'($urandom_range(131072, 0) - 65536);
    m.mzz = DATA_W'($urandom_range(131072, 0) - 65536);
    m.mww = (kind < 5) ? 20'h10000 : DATA_W'($urandom_range(300000, 1));
    if (kind == 9) begin
      m.mxx = pick_val(); m.mxy = pick_val(); m.mxz = pick_val(); m.myx = pick_val();
      m.myy = pick_val(); m.myz = pick_val(); m.mzx = pick_val(); m.mzy = pick_val();
      m.mzz = pick_val(); m.mww = pick_val();
    end else if (kind == 8) begin
      raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom()};
      m = raw[$bits(in_t)-1:0];
    end
    return m;
  endfunction

  task automatic send_mat(in_t m);
    in_valid <= 1'b1;
    in_data <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if ($urandom_range(3, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  function automatic in_t mk(int xx, int yy, int zz, int ww, int off);
    in_t m;
    m = '0;
    m.mxx = DATA_W'(xx); m.myy = DATA_W'(yy); m.mzz = DATA_W'(zz); m.mww = DATA_W'(ww);
    m.mxy = DATA_W'(off); m.myx = DATA_W'(-off); m.mxz = DATA_W'(off);
    m.mzx = DATA_W'(off); m.myz = DATA_W'(-off); m.mzy = DATA_W'(off);
    return m;
  endfunction

  initial begin
    in_t d[$];
    sent = 0;
    rst = 1; in_valid = 0; in_data = '0;
    repeat (4) @(posedge clk);
    rst <= 0;
    d.push_back(mk(65536, 65536, 65536, 65536, 0));
    d.push_back(mk(65536, -65536, -65536, 65536, 1000));
    d.push_back(mk(-65536, 65536, -65536, 65536, 1000));
    d.push_back(mk(-65536, -65536, 65536, 65536, 1000));
    d.push_back(mk(-60000, -60000, -60000, 65536, 500));
    d.push_back(mk(-60000, -60000, -70000, 65536, 500));
    d.push_back(mk(-70000, -60000, -60000, 65536, 500));
    d.push_back(mk(-100000, -100000, -100000, 65536, 0));
    d.push_back(mk(0, 0, 0, 0, 0));
    d.push_back(mk(65536, 65536, 65536, -65536, 0));
    d.push_back(mk(65536, 65536, 65536, 262144, 3000));
    d.push_back(mk(-1, -1, -1, 1, 0));
    d.push_back(mk(0, 0, 0, 1, 524287));
    d.push_back(mk(524287, 524287, 524287, 524287, -524288));
    d.push_back(mk(-524288, -524288, -524288, 524287, 524287));
    d.push_back(mk(-524288, 524287, -524288, 524287, -524288));
    d.push_back(mk(-524288, -524288, 524287, 524287, 524287));
    d.push_back(mk(524287, -524288, -524288, 524287, 524287));
    d.push_back(mk(0, 0, 0, -524288, 0));
    d.push_back(mk(-2, 0, 0, 1, 0));
    foreach (d[i]) send_mat(d[i]);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < N_RAND; i++) begin
      if (i == N_RAND / 2) begin
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
      send_mat(rand_mat());
      if ($urandom_range(40, 0) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(30, 1)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
    $display("sent %0d matrices, checked %0d quaternions", sent, checked);
    $display("covered trace and diagonal branches, scaling, saturation and invalid cases");
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
